// ===== sv/tdfsm_pkg.sv =====
// Shared types and constants for the table-driven transition engine.
// Payload structs, operation and status codes, and the controller/datapath link.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tdfsm_pkg;

    localparam int TABLE_DEPTH    = 16;
    localparam int STATE_BITS     = 5;
    localparam int EVENT_BITS     = 5;
    localparam int SLOT_BITS      = 4;
    localparam int IDX_W          = $clog2(TABLE_DEPTH);
    localparam int ENTRY_W        = 2 * STATE_BITS + EVENT_BITS;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 5;

    typedef logic [STATE_BITS-1:0] state_code_t;
    typedef logic [EVENT_BITS-1:0] event_code_t;

    localparam state_code_t INITIAL_STATE_RESET = state_code_t'(1);
    localparam state_code_t HALT_STATE_RESET    = state_code_t'(0);
    localparam event_code_t TIMEOUT_EVENT_RESET = event_code_t'(1);

    typedef enum logic [1:0] {
        OP_POST    = 2'd0,
        OP_WRITE   = 2'd1,
        OP_RESTART = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        STS_OK        = 3'd0,
        STS_BAD_EVENT = 3'd1,
        STS_HALTED    = 3'd2,
        STS_WRITTEN   = 3'd3,
        STS_RESTARTED = 3'd4
    } status_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_INITIAL_STATE = 2'd0,
        CFG_HALT_STATE    = 2'd1,
        CFG_TIMEOUT_EVENT = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        op_t                  operation;
        event_code_t          event_code;
        logic [SLOT_BITS-1:0] entry_index;
        state_code_t          entry_from;
        event_code_t          entry_event;
        state_code_t          entry_to;
    } in_item_t;

    typedef struct packed {
        status_t     status;
        state_code_t current_state;
        state_code_t saved_state;
        logic        entered_flag;
        logic        timeout_flag;
    } out_item_t;

    typedef struct packed {
        state_code_t ent_from;
        event_code_t ent_event;
        state_code_t ent_to;
    } table_entry_t;

    typedef struct packed {
        logic load_item;
        logic scan_step;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_is_post;
        logic scan_done;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== sv/tdfsm_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; holds the transition table.
`timescale 1ns / 1ps
`default_nettype none

module tdfsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== sv/tdfsm_ctrl.sv =====
// Sequencing controller: accept, table scan, finish and result hand-off.
// Depends on tdfsm_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module tdfsm_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    input  wire tdfsm_pkg::dp_status_t sts,
    output tdfsm_pkg::ctrl_cmd_t      cmd
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_ready;
        s_ready        = 1'b0;
        cmd            = '0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = sts.in_is_post ? ST_SCAN : ST_FINISH;
                end
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // The result register must be free, or be emptied in this cycle.
                if (!out_valid_reg || m_ready) begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== sv/tdfsm_dp.sv =====
// Datapath: configuration registers, machine state, table storage and scan logic.
// Depends on tdfsm_pkg and tdfsm_ram.
`timescale 1ns / 1ps
`default_nettype none

module tdfsm_dp (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire logic                                    cfg_wr_en,
    input  wire logic [tdfsm_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  wire logic [tdfsm_pkg::CFG_DATA_BITS-1:0]     cfg_wdata,
    input  wire tdfsm_pkg::in_item_t                     s_data,
    input  wire tdfsm_pkg::ctrl_cmd_t                    cmd,
    output tdfsm_pkg::dp_status_t                        sts,
    output tdfsm_pkg::out_item_t                         m_data
);

    localparam int IDX_W = tdfsm_pkg::IDX_W;

    tdfsm_pkg::state_code_t initial_state_reg;
    tdfsm_pkg::state_code_t halt_state_reg;
    tdfsm_pkg::event_code_t timeout_event_reg;

    tdfsm_pkg::in_item_t    item_reg;
    tdfsm_pkg::state_code_t present_reg, present_next;
    tdfsm_pkg::state_code_t return_reg, return_next;
    tdfsm_pkg::out_item_t   m_data_reg, m_data_next;

    logic [IDX_W-1:0]                 scan_idx_reg, rd_addr;
    logic                             exact_hit_reg, wild_hit_reg;
    tdfsm_pkg::state_code_t           exact_to_reg, wild_to_reg;
    logic [tdfsm_pkg::TABLE_DEPTH-1:0] valid_reg;
    logic                             rd_valid_reg;

    logic [tdfsm_pkg::ENTRY_W-1:0] rd_raw;
    tdfsm_pkg::table_entry_t       entry, wr_entry;
    logic [IDX_W-1:0]              wr_addr;
    logic                          tbl_we, slot_in_range;

    logic entry_live, exact_now, wild_now, last_slot, tmo_match;
    tdfsm_pkg::state_code_t next_code;

    tdfsm_ram #(
        .WIDTH(tdfsm_pkg::ENTRY_W),
        .DEPTH(tdfsm_pkg::TABLE_DEPTH)
    ) u_table (
        .aclk   (aclk),
        .wr_en  (cmd.commit && tbl_we),
        .wr_addr(wr_addr),
        .wr_data(wr_entry),
        .rd_addr(rd_addr),
        .rd_data(rd_raw)
    );

    // A slot never written since reset reads as an empty entry.
    assign entry = rd_valid_reg ? tdfsm_pkg::table_entry_t'(rd_raw) : '0;

    assign entry_live = entry.ent_event != '0;
    assign exact_now  = entry_live && (entry.ent_event == item_reg.event_code)
                        && (entry.ent_from == present_reg);
    assign wild_now   = entry_live && (entry.ent_event == item_reg.event_code)
                        && (entry.ent_from == '0);
    assign last_slot  = scan_idx_reg == IDX_W'(tdfsm_pkg::TABLE_DEPTH - 1);

    assign sts.scan_done  = !entry_live || exact_now || last_slot;
    assign sts.in_is_post = s_data.operation == tdfsm_pkg::OP_POST;

    // Slot 0 is prefetched while idle so the first scan cycle has its data.
    assign rd_addr = (cmd.scan_step && !sts.scan_done) ? scan_idx_reg + IDX_W'(1) : '0;

    assign wr_addr        = IDX_W'(item_reg.entry_index);
    assign slot_in_range  = 32'(item_reg.entry_index) < 32'(tdfsm_pkg::TABLE_DEPTH);
    assign wr_entry.ent_from  = item_reg.entry_from;
    assign wr_entry.ent_event = item_reg.entry_event;
    assign wr_entry.ent_to    = item_reg.entry_to;

    assign tmo_match = item_reg.event_code == timeout_event_reg;

    always_comb begin
        present_next = present_reg;
        return_next  = return_reg;
        next_code    = '0;
        tbl_we       = 1'b0;
        m_data_next  = '0;
        m_data_next.status = tdfsm_pkg::STS_BAD_EVENT;
        case (item_reg.operation)
            tdfsm_pkg::OP_POST: begin
                if (exact_hit_reg) begin
                    if (exact_to_reg == '0) begin
                        next_code   = return_reg;
                        return_next = initial_state_reg;
                    end else begin
                        next_code = exact_to_reg;
                    end
                end else if (wild_hit_reg) begin
                    if (wild_to_reg == '0) begin
                        next_code = present_reg;
                    end else begin
                        next_code   = wild_to_reg;
                        return_next = present_reg;
                    end
                end
                // A match that lands on state code zero counts as no match.
                if (next_code != '0) begin
                    present_next             = next_code;
                    m_data_next.timeout_flag = tmo_match;
                    m_data_next.entered_flag = (next_code != present_reg) || tmo_match;
                    if (halt_state_reg != '0 && next_code == halt_state_reg) begin
                        m_data_next.status = tdfsm_pkg::STS_HALTED;
                    end else begin
                        m_data_next.status = tdfsm_pkg::STS_OK;
                    end
                end
            end
            tdfsm_pkg::OP_WRITE: begin
                tbl_we             = slot_in_range;
                m_data_next.status = tdfsm_pkg::STS_WRITTEN;
            end
            tdfsm_pkg::OP_RESTART: begin
                present_next       = initial_state_reg;
                return_next        = initial_state_reg;
                m_data_next.status = tdfsm_pkg::STS_RESTARTED;
            end
            default: begin
            end
        endcase
        m_data_next.current_state = present_next;
        m_data_next.saved_state   = return_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            initial_state_reg <= tdfsm_pkg::INITIAL_STATE_RESET;
            halt_state_reg    <= tdfsm_pkg::HALT_STATE_RESET;
            timeout_event_reg <= tdfsm_pkg::TIMEOUT_EVENT_RESET;
            present_reg       <= tdfsm_pkg::INITIAL_STATE_RESET;
            return_reg        <= tdfsm_pkg::INITIAL_STATE_RESET;
            scan_idx_reg      <= '0;
            exact_hit_reg     <= 1'b0;
            wild_hit_reg      <= 1'b0;
            valid_reg         <= '0;
            rd_valid_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    tdfsm_pkg::CFG_INITIAL_STATE: initial_state_reg <= cfg_wdata;
                    tdfsm_pkg::CFG_HALT_STATE:    halt_state_reg    <= cfg_wdata;
                    tdfsm_pkg::CFG_TIMEOUT_EVENT: timeout_event_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
            scan_idx_reg <= rd_addr;
            rd_valid_reg <= valid_reg[rd_addr];
            if (cmd.load_item) begin
                exact_hit_reg <= 1'b0;
                wild_hit_reg  <= 1'b0;
            end else if (cmd.scan_step) begin
                if (exact_now) begin
                    exact_hit_reg <= 1'b1;
                end
                if (wild_now && !wild_hit_reg) begin
                    wild_hit_reg <= 1'b1;
                end
            end
            if (cmd.commit) begin
                present_reg <= present_next;
                return_reg  <= return_next;
                if (tbl_we) begin
                    valid_reg[wr_addr] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            item_reg <= s_data;
        end
        if (cmd.scan_step && exact_now) begin
            exact_to_reg <= entry.ent_to;
        end
        if (cmd.scan_step && wild_now && !wild_hit_reg) begin
            wild_to_reg <= entry.ent_to;
        end
        if (cmd.commit) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_data = m_data_reg;

endmodule

`default_nettype wire

// ===== sv/table_driven_fsm_transition_engine.sv =====
// Top level of the programmable table-driven transition engine.
// Depends on tdfsm_pkg, tdfsm_ctrl and tdfsm_dp.
//
//   Port group   Direction  Handshake            Payload
//   s_*          in         s_valid / s_ready    tdfsm_pkg::in_item_t
//   m_*          out        m_valid / m_ready    tdfsm_pkg::out_item_t
//   cfg_*        in         cfg_wr_en            cfg_index, cfg_wdata
//
// A post-event transaction passes through the accepting idle state, a scan of 1 to TABLE_DEPTH
// table slots (one table slot per cycle through the table RAM read port) and the finish state;
// the result is registered in the finish state, and the next transaction is accepted after it.
// Write, restart and unknown operations pass through the idle and finish states only.
// Reset clears the table valid bits at once; no clearing pass is needed.
// A result waiting on m_ready holds the engine in its finish cycle only when the
// next result is ready to be stored; the input is taken again once it is stored.
`timescale 1ns / 1ps
`default_nettype none

module table_driven_fsm_transition_engine (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [tdfsm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [tdfsm_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire tdfsm_pkg::in_item_t                  s_data,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output tdfsm_pkg::out_item_t                      m_data
);

    tdfsm_pkg::ctrl_cmd_t  cmd;
    tdfsm_pkg::dp_status_t sts;

    tdfsm_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .sts    (sts),
        .cmd    (cmd)
    );

    tdfsm_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_data   (s_data),
        .cmd      (cmd),
        .sts      (sts),
        .m_data   (m_data)
    );

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for table_driven_fsm_transition_engine.
// A directed table and constrained-by-hand random traffic run against an in-bench
// transition predictor. Depends on tdfsm_pkg and the engine RTL.
`timescale 1ns / 1ps

module tb_top;
    import tdfsm_pkg::*;

    localparam logic [1:0] OP_UNDEFINED     = 2'd3;
    localparam int         WATCHDOG_CYCLES  = 4000;
    localparam int         RANDOM_PER_PHASE = 175;
    localparam int         SETTLE_CYCLES    = 24;
    localparam int         NUM_PHASES       = 5;

    typedef struct {
        in_item_t  item;
        bit        typed;
        out_item_t result;
    } directed_row_t;

    logic                      aclk      = 1'b0;
    logic                      aresetn   = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_wdata = '0;
    logic                      s_valid   = 1'b0;
    logic                      s_ready;
    in_item_t                  s_data    = '0;
    logic                      m_valid;
    logic                      m_ready   = 1'b0;
    out_item_t                 m_data;

    table_driven_fsm_transition_engine dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // Shadow copy of the engine state and its registers.
    table_entry_t  shadow_table [TABLE_DEPTH];
    state_code_t   shadow_present;
    state_code_t   shadow_return;
    state_code_t   cfg_initial;
    state_code_t   cfg_halt;
    event_code_t   cfg_timeout;

    out_item_t     pending_results [$];
    out_item_t     oldest_expected;
    directed_row_t directed_rows [$];

    int  error_count   = 0;
    int  items_sent    = 0;
    int  results_seen  = 0;
    int  halted_count  = 0;
    int  bad_count     = 0;
    int  phase_count   = 0;
    int  idle_cycles   = 0;
    bit  burst_mode    = 1'b0;

    always #4 aclk = ~aclk;

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function automatic void reset_shadow();
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            shadow_table[i] = '0;
        end
        cfg_initial    = INITIAL_STATE_RESET;
        cfg_halt       = HALT_STATE_RESET;
        cfg_timeout    = TIMEOUT_EVENT_RESET;
        shadow_present = INITIAL_STATE_RESET;
        shadow_return  = INITIAL_STATE_RESET;
    endfunction

    // Applies one transaction to the shadow state and returns the result it gives.
    function automatic out_item_t compute_transition(input in_item_t it);
        out_item_t   res;
        state_code_t prior;
        state_code_t target;
        bit          found;
        bit          scan_end;
        bit          tmo;
        res      = '0;
        found    = 1'b0;
        scan_end = 1'b0;
        target   = '0;
        case (it.operation)
            OP_WRITE: begin
                shadow_table[it.entry_index].ent_from  = it.entry_from;
                shadow_table[it.entry_index].ent_event = it.entry_event;
                shadow_table[it.entry_index].ent_to    = it.entry_to;
                res.status = STS_WRITTEN;
            end
            OP_RESTART: begin
                shadow_present = cfg_initial;
                shadow_return  = cfg_initial;
                res.status     = STS_RESTARTED;
            end
            OP_POST: begin
                prior = shadow_present;
                // Exact pass: an entry whose from-state is the present state.
                for (int i = 0; i < TABLE_DEPTH && !found && !scan_end; i++) begin
                    if (shadow_table[i].ent_event == '0) begin
                        scan_end = 1'b1;
                    end else if (shadow_table[i].ent_from == shadow_present &&
                                 shadow_table[i].ent_event == it.event_code) begin
                        found = 1'b1;
                        if (shadow_table[i].ent_to == '0) begin
                            target        = shadow_return;
                            shadow_return = cfg_initial;
                        end else begin
                            target = shadow_table[i].ent_to;
                        end
                    end
                end
                // Wildcard pass, only reached when the exact pass found nothing.
                scan_end = 1'b0;
                for (int i = 0; i < TABLE_DEPTH && !found && !scan_end; i++) begin
                    if (shadow_table[i].ent_event == '0) begin
                        scan_end = 1'b1;
                    end else if (shadow_table[i].ent_from == '0 &&
                                 shadow_table[i].ent_event == it.event_code) begin
                        found = 1'b1;
                        if (shadow_table[i].ent_to == '0) begin
                            target = shadow_present;
                        end else begin
                            shadow_return = shadow_present;
                            target        = shadow_table[i].ent_to;
                        end
                    end
                end
                // A match that lands on state zero counts as no match at all.
                if (target == '0) begin
                    res.status = STS_BAD_EVENT;
                end else begin
                    tmo              = (it.event_code == cfg_timeout);
                    shadow_present   = target;
                    res.timeout_flag = tmo;
                    res.entered_flag = (target != prior) || tmo;
                    if (cfg_halt != '0 && target == cfg_halt) begin
                        res.status = STS_HALTED;
                    end else begin
                        res.status = STS_OK;
                    end
                end
            end
            default: begin
                res.status = STS_BAD_EVENT;
            end
        endcase
        res.current_state = shadow_present;
        res.saved_state   = shadow_return;
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // States and events are drawn from a small pool so that entries actually match.
    function automatic state_code_t pick_state();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return state_code_t'($urandom_range(1, 6));
        end else if (r < 73) begin
            return cfg_initial;
        end else if (r < 80) begin
            return cfg_halt;
        end
        return state_code_t'($urandom_range(0, 31));
    endfunction

    function automatic event_code_t pick_event();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return event_code_t'($urandom_range(1, 6));
        end else if (r < 85) begin
            return cfg_timeout;
        end
        return event_code_t'($urandom_range(0, 31));
    endfunction

    function automatic in_item_t make_random_item();
        in_item_t                     it;
        logic [31:0]                  word;
        logic [$bits(in_item_t)-1:0]  raw;
        int                           r;
        word = $urandom;
        raw  = word[$bits(in_item_t)-1:0];
        it   = raw;
        r    = $urandom_range(0, 99);
        if (r < 10) begin
            return it;
        end
        if (r < 32) begin
            it.operation = OP_WRITE;
            if ($urandom_range(0, 99) < 85) begin
                it.entry_index = SLOT_BITS'($urandom_range(0, 7));
            end else begin
                it.entry_index = SLOT_BITS'($urandom_range(0, 15));
            end
            it.entry_from  = ($urandom_range(0, 99) < 30) ? state_code_t'(0) : pick_state();
            it.entry_event = ($urandom_range(0, 99) < 6) ? event_code_t'(0) : pick_event();
            it.entry_to    = ($urandom_range(0, 99) < 20) ? state_code_t'(0) : pick_state();
        end else if (r < 37) begin
            it.operation = OP_RESTART;
        end else if (r < 39) begin
            it.operation = op_t'(OP_UNDEFINED);
        end else begin
            it.operation  = OP_POST;
            it.event_code = pick_event();
        end
        return it;
    endfunction

    function automatic in_item_t mk_item(input op_t op, input event_code_t ev,
                                         input logic [SLOT_BITS-1:0] idx,
                                         input state_code_t from_st,
                                         input event_code_t ent_ev,
                                         input state_code_t to_st);
        in_item_t it;
        it.operation   = op;
        it.event_code  = ev;
        it.entry_index = idx;
        it.entry_from  = from_st;
        it.entry_event = ent_ev;
        it.entry_to    = to_st;
        return it;
    endfunction

    function automatic out_item_t mk_result(input status_t sts, input state_code_t cur,
                                            input state_code_t sav);
        out_item_t res;
        res               = '0;
        res.status        = sts;
        res.current_state = cur;
        res.saved_state   = sav;
        return res;
    endfunction

    task automatic add_row(input in_item_t it, input bit typed, input out_item_t res);
        directed_row_t row;
        row.item   = it;
        row.typed  = typed;
        row.result = res;
        directed_rows.push_back(row);
    endtask

    // Presents one transaction and records its expected result once accepted.
    task automatic send_item(input in_item_t it, input bit typed, input out_item_t res);
        out_item_t predicted;
        int        gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        predicted = compute_transition(it);
        if (typed) begin
            predicted = res;
        end
        if (predicted.status == STS_HALTED) halted_count++;
        if (predicted.status == STS_BAD_EVENT) bad_count++;
        pending_results.push_back(predicted);
        items_sent++;
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_INITIAL_STATE: cfg_initial = val;
            CFG_HALT_STATE:    cfg_halt    = val;
            CFG_TIMEOUT_EVENT: cfg_timeout = val;
            default: ;
        endcase
    endtask

    // Result side stalls on its own schedule, independent of m_valid.
    initial begin
        int gap;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            gap = pick_gap();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result transaction with nothing pending");
            end else begin
                oldest_expected = pending_results.pop_front();
                results_seen++;
                if (m_data.status !== oldest_expected.status)
                    report_mismatch($sformatf("status got %0d, expected %0d",
                                              m_data.status, oldest_expected.status));
                if (m_data.current_state !== oldest_expected.current_state)
                    report_mismatch($sformatf("current_state got %0d, expected %0d",
                                              m_data.current_state,
                                              oldest_expected.current_state));
                if (m_data.saved_state !== oldest_expected.saved_state)
                    report_mismatch($sformatf("saved_state got %0d, expected %0d",
                                              m_data.saved_state,
                                              oldest_expected.saved_state));
                if (m_data.entered_flag !== oldest_expected.entered_flag)
                    report_mismatch($sformatf("entered_flag got %0d, expected %0d",
                                              m_data.entered_flag,
                                              oldest_expected.entered_flag));
                if (m_data.timeout_flag !== oldest_expected.timeout_flag)
                    report_mismatch($sformatf("timeout_flag got %0d, expected %0d",
                                              m_data.timeout_flag,
                                              oldest_expected.timeout_flag));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("[%0t] watchdog: no transaction for %0d cycles", $time, idle_cycles);
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        out_item_t none;
        state_code_t phase_init  [NUM_PHASES];
        state_code_t phase_halt  [NUM_PHASES];
        event_code_t phase_tmo   [NUM_PHASES];
        none = '0;
        // Register settings per phase; the third one allows a restart into state zero.
        phase_init = '{5'd2, 5'd31, 5'd0, 5'd1, 5'd0};
        phase_halt = '{5'd9, 5'd31, 5'd0, 5'd1, 5'd0};
        phase_tmo  = '{5'd3, 5'd31, 5'd0, 5'd1, 5'd0};
        phase_init[4] = state_code_t'($urandom_range(1, 31));
        phase_halt[4] = state_code_t'($urandom_range(0, 31));
        phase_tmo[4]  = event_code_t'($urandom_range(1, 31));

        reset_shadow();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty table, unknown operation and restart right after reset.
        add_row(mk_item(OP_POST, 5'd5, 4'd0, 5'd0, 5'd0, 5'd0), 1'b1,
                mk_result(STS_BAD_EVENT, 5'd1, 5'd1));
        add_row(mk_item(OP_POST, 5'd0, 4'd0, 5'd0, 5'd0, 5'd0), 1'b1,
                mk_result(STS_BAD_EVENT, 5'd1, 5'd1));
        add_row(mk_item(op_t'(OP_UNDEFINED), 5'd31, 4'd15, 5'd31, 5'd31, 5'd31), 1'b1,
                mk_result(STS_BAD_EVENT, 5'd1, 5'd1));
        add_row(mk_item(OP_RESTART, 5'd0, 4'd0, 5'd0, 5'd0, 5'd0), 1'b1,
                mk_result(STS_RESTARTED, 5'd1, 5'd1));
        // Exact jump, wildcard jump, exact return, wildcard ignore, all-ones entry.
        add_row(mk_item(OP_WRITE, 5'd0, 4'd0, 5'd1, 5'd2, 5'd3), 1'b1,
                mk_result(STS_WRITTEN, 5'd1, 5'd1));
        add_row(mk_item(OP_WRITE, 5'd0, 4'd1, 5'd0, 5'd4, 5'd7), 1'b1,
                mk_result(STS_WRITTEN, 5'd1, 5'd1));
        add_row(mk_item(OP_WRITE, 5'd0, 4'd2, 5'd7, 5'd5, 5'd0), 1'b1,
                mk_result(STS_WRITTEN, 5'd1, 5'd1));
        add_row(mk_item(OP_WRITE, 5'd0, 4'd3, 5'd0, 5'd6, 5'd0), 1'b1,
                mk_result(STS_WRITTEN, 5'd1, 5'd1));
        add_row(mk_item(OP_WRITE, 5'd0, 4'd4, 5'd31, 5'd31, 5'd31), 1'b1,
                mk_result(STS_WRITTEN, 5'd1, 5'd1));
        add_row(mk_item(OP_POST, 5'd2, 4'd0, 5'd0, 5'd0, 5'd0), 1'b0, none);
        add_row(mk_item(OP_POST, 5'd4, 4'd0, 5'd0, 5'd0, 5'd0), 1'b0, none);
        add_row(mk_item(OP_POST, 5'd5, 4'd0, 5'd0, 5'd0, 5'd0), 1'b0, none);
        add_row(mk_item(OP_POST, 5'd6, 4'd0, 5'd0, 5'd0, 5'd0), 1'b0, none);
        add_row(mk_item(OP_POST, 5'd1, 4'd0, 5'd0, 5'd0, 5'd0), 1'b0, none);
        // Self loop on the timeout event still reports entered.
        add_row(mk_item(OP_WRITE, 5'd0, 4'd5, 5'd3, 5'd1, 5'd3), 1'b0, none);
        add_row(mk_item(OP_POST, 5'd1, 4'd0, 5'd0, 5'd0, 5'd0), 1'b0, none);
        add_row(mk_item(OP_WRITE, 5'd0, 4'd15, 5'd31, 5'd31, 5'd31), 1'b0, none);
        add_row(mk_item(OP_POST, 5'd31, 4'd0, 5'd0, 5'd0, 5'd0), 1'b0, none);
        // An end marker in slot 3 hides everything after it.
        add_row(mk_item(OP_WRITE, 5'd0, 4'd3, 5'd0, 5'd0, 5'd5), 1'b0, none);
        add_row(mk_item(OP_POST, 5'd6, 4'd0, 5'd0, 5'd0, 5'd0), 1'b0, none);
        add_row(mk_item(OP_RESTART, 5'd31, 4'd15, 5'd31, 5'd31, 5'd31), 1'b0, none);
        add_row(mk_item(OP_POST, 5'd31, 4'd0, 5'd0, 5'd0, 5'd0), 1'b0, none);

        foreach (directed_rows[i]) begin
            send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].result);
        end
        settle();
        phase_count = 1;

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_register(CFG_INITIAL_STATE, phase_init[p]);
            write_register(CFG_HALT_STATE, phase_halt[p]);
            write_register(CFG_TIMEOUT_EVENT, phase_tmo[p]);
            phase_count++;
            send_item(mk_item(OP_RESTART, 5'd0, 4'd0, 5'd0, 5'd0, 5'd0), 1'b0, none);
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                if (n % 50 == 0) begin
                    burst_mode = ($urandom_range(0, 3) == 0);
                end
                send_item(make_random_item(), 1'b0, none);
            end
            settle();
        end

        $display("Ran %0d transactions under %0d register settings, %0d results compared.",
                 items_sent, phase_count, results_seen);
        $display("Outcomes included %0d halted and %0d bad-event results.",
                 halted_count, bad_count);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/tdfsm_pkg.sv
sv/tdfsm_ram.sv
sv/tdfsm_ctrl.sv
sv/tdfsm_dp.sv
sv/table_driven_fsm_transition_engine.sv
dv/tb_top.sv
